@@ design/sbps_pkg.sv @@
// -----------------------------------------------------------------------------
// sbps_pkg
// Shared types and constants for the sphere Brownian particle step unit.
// -----------------------------------------------------------------------------
`default_nettype none
package sbps_pkg;

   localparam int PARTICLES     = 1024;
   localparam int IDX_W         = $clog2(PARTICLES);
   localparam int FRACTION_BITS = 16;
   localparam int POS_W         = 28;
   localparam int TICK_W        = 26;
   localparam int CORDIC_STEPS  = 30;
   localparam int ITER_W        = 5;
   localparam int ANG_W         = 34;
   localparam int CXY_W         = 34;
   localparam int SQ_W          = 64;

   localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic [30:0] ONE_Q30 = 31'd1073741824;

   // configuration register indexes
   localparam logic [2:0] CSR_RADIUS_SQ   = 3'd0;
   localparam logic [2:0] CSR_INV_RADIUS  = 3'd1;
   localparam logic [2:0] CSR_THRESHOLD   = 3'd2;
   localparam logic [2:0] CSR_TICKS_RAD   = 3'd3;
   localparam logic [2:0] CSR_REINJECT_Z  = 3'd4;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_STEP = 1'b1;

   typedef struct packed {
      logic                    opcode;
      logic [IDX_W-1:0]        particle;
      logic signed [POS_W-1:0] value_x;
      logic signed [POS_W-1:0] value_y;
      logic signed [POS_W-1:0] value_z;
      logic [31:0]             uniform_sample;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]        particle_out;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic [TICK_W-1:0]       ticks_left;
      logic                    free_after;
      logic                    absorbed;
   } rsp_type;

   typedef struct packed {
      logic [55:0]             radius_sq;
      logic [31:0]             inverse_radius;
      logic [31:0]             absorb_threshold;
      logic [23:0]             ticks_per_radian;
      logic signed [POS_W-1:0] reinject_z;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic capture;     // latch request, issue memory read
      logic eval;        // latch memory data, compute new position
      logic square;      // square coordinates
      logic decide;      // sum and compare
      logic acos_setup;  // u from z0
      logic sqrt_step;   // root seed, then one root digit
      logic cordic_init;
      logic cordic_step;
      logic timer;       // tick product
      logic commit;      // write back and present result
      logic clear;       // zero one tick entry after reset
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_load;
      logic is_bound;
      logic absorb;
      logic sqrt_last;
      logic cordic_last;
      logic clear_last;
   } sts_type;

   // atan(2^-i) in Q30
   function automatic logic [29:0] atan_q30(input logic [ITER_W-1:0] i);
      logic [29:0] r;
      begin
         r = '0;
         case (i)
            5'd0:  r = 30'd843314857;
            5'd1:  r = 30'd497837829;
            5'd2:  r = 30'd263043836;
            5'd3:  r = 30'd133525159;
            5'd4:  r = 30'd67021687;
            5'd5:  r = 30'd33543516;
            5'd6:  r = 30'd16775851;
            5'd7:  r = 30'd8388437;
            5'd8:  r = 30'd4194283;
            5'd9:  r = 30'd2097149;
            default: r = 30'd1 << (5'd30 - i);
         endcase
         return r;
      end
   endfunction

   function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                                input logic [POS_W-1:0] b);
      logic [POS_W:0] s;
      begin
         s = {a[POS_W-1], a} + {b[POS_W-1], b};
         if (s[POS_W] != s[POS_W-1]) begin
            return s[POS_W] ? POS_MIN : POS_MAX;
         end
         return s[POS_W-1:0];
      end
   endfunction

endpackage
`default_nettype wire

@@ design/sbps_ram.sv @@
// -----------------------------------------------------------------------------
// sbps_ram
// Generic single-port write, single-port read RAM with registered read data.
// -----------------------------------------------------------------------------
`default_nettype none
module sbps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

@@ design/sbps_ctrl.sv @@
// -----------------------------------------------------------------------------
// sbps_ctrl
// Sequencer for the particle step: memory read, boundary test, and the
// optional square-root plus CORDIC arccosine for absorbed particles.
// -----------------------------------------------------------------------------
`default_nettype none
module sbps_ctrl
   import sbps_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire sts_type sts,
   output logic         busy,
   output cmd_type      cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_READ   = 4'd1;
   localparam logic [3:0] S_SQUARE = 4'd2;
   localparam logic [3:0] S_DECIDE = 4'd3;
   localparam logic [3:0] S_USETUP = 4'd4;
   localparam logic [3:0] S_SQRT   = 4'd5;
   localparam logic [3:0] S_CINIT  = 4'd6;
   localparam logic [3:0] S_CORDIC = 4'd7;
   localparam logic [3:0] S_TIMER  = 4'd8;
   localparam logic [3:0] S_COMMIT = 4'd9;
   localparam logic [3:0] S_CLEAR  = 4'd10;

   logic [3:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_READ;
            end
         end
         S_READ: begin
            cmd.eval = 1'b1;
            state_in = S_SQUARE;
         end
         S_SQUARE: begin
            if (sts.is_load || sts.is_bound) begin
               state_in = S_COMMIT;
            end else begin
               cmd.square = 1'b1;
               state_in   = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = S_USETUP;
         end
         S_USETUP: begin
            if (sts.absorb) begin
               cmd.acos_setup = 1'b1;
               state_in       = S_SQRT;
            end else begin
               state_in = S_COMMIT;
            end
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (sts.sqrt_last) begin
               state_in = S_CINIT;
            end
         end
         S_CINIT: begin
            cmd.cordic_init = 1'b1;
            state_in        = S_CORDIC;
         end
         S_CORDIC: begin
            cmd.cordic_step = 1'b1;
            if (sts.cordic_last) begin
               state_in = S_TIMER;
            end
         end
         S_TIMER: begin
            cmd.timer = 1'b1;
            state_in  = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold state; start with the tick clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule
`default_nettype wire

@@ design/sbps_datapath.sv @@
// -----------------------------------------------------------------------------
// sbps_datapath
// Particle tables, position update, radius test, bit-serial square root,
// CORDIC vectoring arccosine and bound-tick bookkeeping.
// -----------------------------------------------------------------------------
`default_nettype none
module sbps_datapath
   import sbps_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire req_type req,
   input  wire cfg_type cfg,
   input  wire cmd_type cmd,
   output sts_type      sts,
   output logic         rsp_valid,
   output rsp_type      rsp
);

   localparam int POS_RAM_W = 3 * POS_W;

   // request hold
   req_type req_ff;

   // position and tick tables
   logic [POS_RAM_W-1:0] pos_rd, pos_wr;
   logic [TICK_W-1:0]    tick_rd, tick_wr;
   logic                 wr_en;
   logic                 tick_wr_en;
   logic [IDX_W-1:0]     tick_wr_addr;
   logic [TICK_W-1:0]    tick_wr_data;
   logic [IDX_W-1:0]     clr_addr_ff;

   sbps_ram #(.WIDTH(POS_RAM_W), .DEPTH(PARTICLES)) u_pos_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(req_ff.particle),
      .wr_data(pos_wr),
      .rd_addr(req.particle),
      .rd_data(pos_rd)
   );

   sbps_ram #(.WIDTH(TICK_W), .DEPTH(PARTICLES)) u_tick_ram (
      .clock  (clock),
      .wr_en  (tick_wr_en),
      .wr_addr(tick_wr_addr),
      .wr_data(tick_wr_data),
      .rd_addr(req.particle),
      .rd_data(tick_rd)
   );

   // working registers
   logic [POS_W-1:0]  old_x_ff, old_y_ff, old_z_ff;
   logic [POS_W-1:0]  new_x_ff, new_y_ff, new_z_ff;
   logic [TICK_W-1:0] ticks_ff;
   logic              bound_ff;
   logic [55:0]       sqx_ff, sqy_ff, sqz_ff;
   logic              outside_ff, absorb_ff;
   logic [30:0]       u_ff;
   logic [61:0]       rem_ff;
   logic [30:0]       root_ff;
   logic [ITER_W-1:0] iter_ff;
   logic signed [CXY_W-1:0] cx_ff, cy_ff;
   logic signed [ANG_W-1:0] ang_ff;
   logic [TICK_W-1:0] timer_ff;
   logic              rsp_valid_ff;

   // tick write port: clearing pass after reset, else commit
   assign tick_wr_en   = cmd.commit || cmd.clear;
   assign tick_wr_addr = cmd.clear ? clr_addr_ff : req_ff.particle;
   assign tick_wr_data = cmd.clear ? '0 : tick_wr;

   // magnitude of z0 times 1/R
   logic [POS_W-1:0] zmag;
   logic [59:0]      uprod;
   assign zmag  = old_z_ff[POS_W-1] ? (~old_z_ff + 1'b1) : old_z_ff;
   assign uprod = {32'd0, zmag} * {28'd0, cfg.inverse_radius};

   // one root digit: restoring square root of 2^60 - u^2
   logic [30:0] sq_bit;
   logic [61:0] usq;
   logic [61:0] cand;
   assign sq_bit = 31'd1 << (5'd31 - iter_ff);
   assign usq    = {31'd0, u_ff} * {31'd0, u_ff};
   assign cand   = ({31'd0, root_ff} << (6'd32 - {1'b0, iter_ff}))
                 + ({31'd0, sq_bit} << (6'd31 - {1'b0, iter_ff}));

   // CORDIC step
   logic signed [CXY_W-1:0] dx, dy;
   logic signed [ANG_W-1:0] ang_a, ang_cl, theta;
   assign dx    = cy_ff >>> iter_ff;
   assign dy    = cx_ff >>> iter_ff;
   assign ang_a = {4'd0, atan_q30(iter_ff)};
   always_comb begin
      ang_cl = ang_ff;
      if (ang_ff < 0) begin
         ang_cl = '0;
      end else if (ang_ff > HALF_PI_Q30) begin
         ang_cl = HALF_PI_Q30;
      end
      theta = old_z_ff[POS_W-1] ? (PI_Q30 - ang_cl) : ang_cl;
   end

   logic [55:0] tprod;
   assign tprod = {32'd0, cfg.ticks_per_radian} * {22'd0, theta[ANG_W-1:0]};

   logic [57:0] r2;
   assign r2 = {2'b0, sqx_ff} + {2'b0, sqy_ff} + {2'b0, sqz_ff};

   logic [55:0] square_x, square_y, square_z;
   assign square_x = 56'($signed(new_x_ff) * $signed(new_x_ff));
   assign square_y = 56'($signed(new_y_ff) * $signed(new_y_ff));
   assign square_z = 56'($signed(new_z_ff) * $signed(new_z_ff));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req;
      end
      if (cmd.eval) begin
         old_x_ff <= pos_rd[3*POS_W-1:2*POS_W];
         old_y_ff <= pos_rd[2*POS_W-1:POS_W];
         old_z_ff <= pos_rd[POS_W-1:0];
         new_x_ff <= sat_add(pos_rd[3*POS_W-1:2*POS_W], req_ff.value_x);
         new_y_ff <= sat_add(pos_rd[2*POS_W-1:POS_W], req_ff.value_y);
         new_z_ff <= sat_add(pos_rd[POS_W-1:0], req_ff.value_z);
         ticks_ff <= tick_rd;
         bound_ff <= (tick_rd != '0);
         absorb_ff <= 1'b0;
      end
      if (cmd.square) begin
         sqx_ff <= square_x;
         sqy_ff <= square_y;
         sqz_ff <= square_z;
      end
      if (cmd.decide) begin
         outside_ff <= (r2 >= {2'b0, cfg.radius_sq});
         absorb_ff  <= (r2 >= {2'b0, cfg.radius_sq})
                       && (req_ff.uniform_sample < cfg.absorb_threshold);
      end
      if (cmd.acos_setup) begin
         u_ff    <= (uprod[59:FRACTION_BITS+2] > {11'd0, ONE_Q30})
                    ? ONE_Q30 : uprod[FRACTION_BITS+32:FRACTION_BITS+2];
         root_ff <= '0;
         iter_ff <= '0;
      end
      // seed the remainder, then settle one root bit per cycle
      if (cmd.sqrt_step) begin
         if (iter_ff == 5'd0) begin
            rem_ff <= (62'd1 << 60) - usq;
         end else if (rem_ff >= cand) begin
            rem_ff  <= rem_ff - cand;
            root_ff <= root_ff | sq_bit;
         end
         iter_ff <= iter_ff + 1'b1;
      end
      if (cmd.cordic_init) begin
         cx_ff   <= {3'd0, u_ff};
         cy_ff   <= {3'd0, root_ff};
         ang_ff  <= '0;
         iter_ff <= '0;
      end
      if (cmd.cordic_step) begin
         if (cy_ff >= 0) begin
            cx_ff  <= cx_ff + dx;
            cy_ff  <= cy_ff - dy;
            ang_ff <= ang_ff + ang_a;
         end else begin
            cx_ff  <= cx_ff - dx;
            cy_ff  <= cy_ff + dy;
            ang_ff <= ang_ff - ang_a;
         end
         iter_ff <= iter_ff + 1'b1;
      end
      if (cmd.timer) begin
         timer_ff <= TICK_W'((tprod >> 30) + 56'd1);
      end
   end

   // write-back data and result
   always_comb begin
      wr_en   = cmd.commit;
      pos_wr  = {old_x_ff, old_y_ff, old_z_ff};
      tick_wr = ticks_ff;
      if (req_ff.opcode == OP_LOAD) begin
         pos_wr  = {req_ff.value_x, req_ff.value_y, req_ff.value_z};
         tick_wr = '0;
      end else if (bound_ff) begin
         tick_wr = ticks_ff - 1'b1;
      end else if (absorb_ff) begin
         pos_wr  = {{POS_W{1'b0}}, {POS_W{1'b0}}, cfg.reinject_z};
         tick_wr = timer_ff;
      end else if (!outside_ff) begin
         pos_wr = {new_x_ff, new_y_ff, new_z_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         clr_addr_ff  <= '0;
      end else begin
         rsp_valid_ff <= cmd.commit;
         if (cmd.clear) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
         end
      end
      if (cmd.commit) begin
         rsp.particle_out <= req_ff.particle;
         rsp.pos_x        <= pos_wr[3*POS_W-1:2*POS_W];
         rsp.pos_y        <= pos_wr[2*POS_W-1:POS_W];
         rsp.pos_z        <= pos_wr[POS_W-1:0];
         rsp.ticks_left   <= tick_wr;
         rsp.free_after   <= (tick_wr == '0);
         rsp.absorbed     <= (req_ff.opcode == OP_STEP) && !bound_ff && absorb_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   assign sts.is_load     = (req_ff.opcode == OP_LOAD);
   assign sts.is_bound    = bound_ff;
   assign sts.absorb      = absorb_ff;
   assign sts.sqrt_last   = (iter_ff == 5'd31);
   assign sts.cordic_last = (iter_ff == 5'(CORDIC_STEPS - 1));
   assign sts.clear_last  = (clr_addr_ff == IDX_W'(PARTICLES - 1));

endmodule
`default_nettype wire

@@ design/sphere_brownian_particle_step_unit.sv @@
// A load or a bound step runs read, square and commit; a free step that stays
// or bounces adds decide and u-setup; an absorption adds a root seed, 31 root
// digits and 30 CORDIC iterations on one shared iteration counter, then the
// tick product. One item at a time; start is taken again in the cycle of the
// result strobe. The result cannot be stalled. Synchronous reset clears control,
// then busy stays high for a pass that zeroes every bound-tick entry, marking all free.
// -----------------------------------------------------------------------------
// sphere_brownian_particle_step_unit
// Top level: configuration registers, controller and datapath.
// -----------------------------------------------------------------------------
`default_nettype none
module sphere_brownian_particle_step_unit
   import sbps_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [55:0] csr_data
);

   cfg_type cfg_ff;
   cmd_type cmd;
   sts_type sts;
   logic    ctrl_busy;

   // configuration beat
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radius_sq        <= 56'd1073741824000000;
         cfg_ff.inverse_radius   <= 32'd8589935;
         cfg_ff.absorb_threshold <= 32'd24072292;
         cfg_ff.ticks_per_radian <= 24'd50000;
         cfg_ff.reinject_z       <= 28'sd32440320;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_RADIUS_SQ:  cfg_ff.radius_sq        <= csr_data;
            CSR_INV_RADIUS: cfg_ff.inverse_radius   <= csr_data[31:0];
            CSR_THRESHOLD:  cfg_ff.absorb_threshold <= csr_data[31:0];
            CSR_TICKS_RAD:  cfg_ff.ticks_per_radian <= csr_data[23:0];
            CSR_REINJECT_Z: cfg_ff.reinject_z       <= csr_data[POS_W-1:0];
            default: ;
         endcase
      end
   end

   sbps_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .sts(sts),
      .busy(ctrl_busy), .cmd(cmd)
   );

   sbps_datapath u_dp (
      .clock(clock), .reset(reset), .req(req_data), .cfg(cfg_ff), .cmd(cmd),
      .sts(sts), .rsp_valid(rsp_valid), .rsp(rsp_data)
   );

   assign busy = ctrl_busy;

   // strobe follows a commit only
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cmd.commit)) else $error("strobe without commit");
   // a start in idle raises busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("start not taken");
   // one strobe per item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("double strobe");

endmodule
`default_nettype wire
